>>> rtl/heq_pkg.sv
// shared types, constants and state codes of the histogram equalizer
package heq_pkg;

   localparam int DEF_LEVELS     = 256;
   localparam int DEF_COUNT_BITS = 24;

   localparam int CHAN_W = 8;

   // floor(s/3) as (s*683)>>11, exact for s < 2048
   localparam int SUM_W       = 10;
   localparam int GRAY_RECIP  = 683;
   localparam int GRAY_SHIFT  = 11;
   localparam int PROD_W      = 20;
   localparam int GRAY_W      = PROD_W - GRAY_SHIFT;

   localparam logic OP_COUNT = 1'b0;
   localparam logic OP_MAP   = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
      logic              end_of_frame;
   } heq_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
   } heq_rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CNT_WR,
      ST_MAP_G,
      ST_MAP_B,
      ST_MAP_OUT,
      ST_BLD_RD,
      ST_BLD_SUM,
      ST_BLD_MUL,
      ST_BLD_CHK,
      ST_BLD_DIV,
      ST_BLD_WR
   } heq_state_type;

endpackage

>>> rtl/heq_if.sv
// valid/ready channel interfaces for pixel requests and equalized responses
interface heq_req_if import heq_pkg::*; ();
   logic        valid;
   logic        ready;
   heq_req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface heq_rsp_if import heq_pkg::*; ();
   logic        valid;
   logic        ready;
   heq_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/histogram_equalizer_unit.sv
// two-pass histogram equalizer: gray histogram count, table build, pixel map
// A count word (opcode count) adds its gray level (r+g+b)/3 to a histogram bin and to
// the pixel total; it gives no response and occupies the unit for one bin memory read
// and then one saturating write back. The count word marked end_of_frame then
// starts the table build: each of the LEVELS bins is read, added to a saturating
// running sum, and its table entry round(cdf*(LEVELS-1)/total) comes out of a
// restoring divider that yields one quotient bit per cycle; bins and total are
// cleared during the build and no word is taken meanwhile. A map word (opcode map)
// looks up its three channels one after another through the single read port of
// the level table, then places the response in the output register once that is
// free; the register holds it until taken while the next word is accepted.
// After reset a clearing pass zeroes both memories before the first word is taken.
module histogram_equalizer_unit import heq_pkg::*; #(
   parameter int LEVELS     = DEF_LEVELS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input logic         clock,
   input logic         reset,
   heq_req_if.sink     req_chan,
   heq_rsp_if.source   rsp_chan
);

   localparam int LVL_W  = $clog2(LEVELS);
   localparam int STEP_W = $clog2(LVL_W);
   localparam int NUM_W  = COUNT_BITS + LVL_W + 2;
   localparam logic [LVL_W-1:0] TOP = LVL_W'(LEVELS - 1);

   // values at or above LEVELS fall into the last bin or entry
   function automatic logic [LVL_W-1:0] clamp_lvl(input logic [GRAY_W-1:0] v);
      return (v >= GRAY_W'(LEVELS)) ? TOP : v[LVL_W-1:0];
   endfunction

   heq_state_type state_ff, state_in;

   logic [LVL_W-1:0]      idx_ff, idx_in;
   logic [LVL_W-1:0]      gray_ff, gray_in;
   logic                  eof_ff, eof_in;
   logic [LVL_W-1:0]      green_ff, green_in;
   logic [LVL_W-1:0]      blue_ff, blue_in;
   logic [CHAN_W-1:0]     red_hold_ff, red_hold_in;
   logic [CHAN_W-1:0]     green_hold_ff, green_hold_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [COUNT_BITS-1:0] run_sum_ff, run_sum_in;
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [NUM_W-1:0]      dsh_ff, dsh_in;
   logic [LVL_W-1:0]      q_ff, q_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   heq_rsp_type           rsp_data_ff, rsp_data_in;

   // histogram bin memory
   logic [COUNT_BITS-1:0] bin_mem [LEVELS];
   logic                  bin_we, bin_re;
   logic [LVL_W-1:0]      bin_waddr, bin_raddr;
   logic [COUNT_BITS-1:0] bin_wdata;
   logic [COUNT_BITS-1:0] bin_rd_ff;

   // level table memory
   logic [CHAN_W-1:0]     tbl_mem [LEVELS];
   logic                  tbl_we, tbl_re;
   logic [LVL_W-1:0]      tbl_waddr, tbl_raddr;
   logic [CHAN_W-1:0]     tbl_wdata;
   logic [CHAN_W-1:0]     tbl_rd_ff;

   // gray level of the incoming pixel
   logic [SUM_W-1:0]      gray_sum;
   logic [PROD_W-1:0]     gray_prod;
   logic [LVL_W-1:0]      gray_lvl;

   // divider helpers
   logic [NUM_W-1:0]      div_base;
   logic [COUNT_BITS:0]   cum_wide;
   logic                  out_free;

   assign gray_sum  = SUM_W'(req_chan.data.red_in) + SUM_W'(req_chan.data.green_in)
                    + SUM_W'(req_chan.data.blue_in);
   assign gray_prod = PROD_W'(gray_sum) * PROD_W'(GRAY_RECIP);
   assign gray_lvl  = clamp_lvl(gray_prod[GRAY_SHIFT +: GRAY_W]);

   // divisor is 2*total
   assign div_base  = NUM_W'({total_ff, 1'b0});
   assign cum_wide  = {1'b0, run_sum_ff} + {1'b0, bin_rd_ff};
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (bin_we) begin
         bin_mem[bin_waddr] <= bin_wdata;
      end
      if (bin_re) begin
         bin_rd_ff <= bin_mem[bin_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      if (tbl_re) begin
         tbl_rd_ff <= tbl_mem[tbl_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         total_ff     <= '0;
         run_sum_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         total_ff     <= total_in;
         run_sum_ff   <= run_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gray_ff       <= gray_in;
      eof_ff        <= eof_in;
      green_ff      <= green_in;
      blue_ff       <= blue_in;
      red_hold_ff   <= red_hold_in;
      green_hold_ff <= green_hold_in;
      num_ff        <= num_in;
      dsh_ff        <= dsh_in;
      q_ff          <= q_in;
      step_ff       <= step_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      gray_in       = gray_ff;
      eof_in        = eof_ff;
      green_in      = green_ff;
      blue_in       = blue_ff;
      red_hold_in   = red_hold_ff;
      green_hold_in = green_hold_ff;
      total_in      = total_ff;
      run_sum_in    = run_sum_ff;
      num_in        = num_ff;
      dsh_in        = dsh_ff;
      q_in          = q_ff;
      step_in       = step_ff;
      rsp_data_in   = rsp_data_ff;
      // response leaves when taken
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;

      bin_we    = 1'b0;
      bin_waddr = idx_ff;
      bin_wdata = '0;
      bin_re    = 1'b0;
      bin_raddr = idx_ff;
      tbl_we    = 1'b0;
      tbl_waddr = idx_ff;
      tbl_wdata = '0;
      tbl_re    = 1'b0;
      tbl_raddr = blue_ff;

      case (state_ff)
         ST_CLEAR: begin
            // zero both memories, one entry per cycle
            bin_we = 1'b1;
            tbl_we = 1'b1;
            idx_in = idx_ff + LVL_W'(1);
            if (idx_ff == TOP) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.data.opcode == OP_MAP) begin
                  // red lookup starts right away
                  tbl_re    = 1'b1;
                  tbl_raddr = clamp_lvl({1'b0, req_chan.data.red_in});
                  green_in  = clamp_lvl({1'b0, req_chan.data.green_in});
                  blue_in   = clamp_lvl({1'b0, req_chan.data.blue_in});
                  state_in  = ST_MAP_G;
               end else begin
                  bin_re    = 1'b1;
                  bin_raddr = gray_lvl;
                  gray_in   = gray_lvl;
                  eof_in    = req_chan.data.end_of_frame;
                  state_in  = ST_CNT_WR;
               end
            end
         end
         ST_CNT_WR: begin
            // saturating bin and total increments
            bin_we    = 1'b1;
            bin_waddr = gray_ff;
            bin_wdata = (&bin_rd_ff) ? bin_rd_ff : bin_rd_ff + COUNT_BITS'(1);
            total_in  = (&total_ff) ? total_ff : total_ff + COUNT_BITS'(1);
            if (eof_ff) begin
               idx_in     = '0;
               run_sum_in = '0;
               state_in   = ST_BLD_RD;
            end else begin
               state_in   = ST_IDLE;
            end
         end
         ST_MAP_G: begin
            red_hold_in = tbl_rd_ff;
            tbl_re      = 1'b1;
            tbl_raddr   = green_ff;
            state_in    = ST_MAP_B;
         end
         ST_MAP_B: begin
            green_hold_in = tbl_rd_ff;
            tbl_re        = 1'b1;
            tbl_raddr     = blue_ff;
            state_in      = ST_MAP_OUT;
         end
         ST_MAP_OUT: begin
            // blue lookup result holds until the output register frees up
            if (out_free) begin
               rsp_data_in.red_out   = red_hold_ff;
               rsp_data_in.green_out = green_hold_ff;
               rsp_data_in.blue_out  = tbl_rd_ff;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         ST_BLD_RD: begin
            bin_re   = 1'b1;
            state_in = ST_BLD_SUM;
         end
         ST_BLD_SUM: begin
            // cumulative sum, bin cleared behind the read
            run_sum_in = cum_wide[COUNT_BITS] ? '1 : cum_wide[COUNT_BITS-1:0];
            bin_we     = 1'b1;
            state_in   = ST_BLD_MUL;
         end
         ST_BLD_MUL: begin
            // numerator 2*cdf*(LEVELS-1) + total
            num_in   = ((NUM_W'(run_sum_ff) * NUM_W'(TOP)) << 1) + NUM_W'(total_ff);
            dsh_in   = div_base << (LVL_W - 1);
            q_in     = '0;
            step_in  = STEP_W'(LVL_W - 1);
            state_in = ST_BLD_CHK;
         end
         ST_BLD_CHK: begin
            if (total_ff == '0) begin
               q_in     = '0;
               state_in = ST_BLD_WR;
            end else if (num_ff >= (div_base << LVL_W)) begin
               // quotient beyond the index range, saturate
               q_in     = '1;
               state_in = ST_BLD_WR;
            end else begin
               state_in = ST_BLD_DIV;
            end
         end
         ST_BLD_DIV: begin
            // one restoring step per cycle
            if (num_ff >= dsh_ff) begin
               num_in = num_ff - dsh_ff;
               q_in   = {q_ff[LVL_W-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[LVL_W-2:0], 1'b0};
            end
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ST_BLD_WR;
            end
         end
         ST_BLD_WR: begin
            tbl_we    = 1'b1;
            tbl_wdata = CHAN_W'((q_ff > TOP) ? TOP : q_ff);
            if (idx_ff == TOP) begin
               idx_in   = '0;
               total_in = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + LVL_W'(1);
               state_in = ST_BLD_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // the marked count word starts the build at the first bin
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CNT_WR && eof_ff) |=> (state_ff == ST_BLD_RD && idx_ff == '0))
      else $error("build did not start after end of frame");

   // restoring divider keeps its remainder below twice the shifted divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BLD_DIV) |-> (num_ff < (dsh_ff << 1)))
      else $error("divider remainder out of range");

   // finishing the last entry clears the total and returns to idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BLD_WR && idx_ff == TOP) |=> (total_ff == '0 && state_ff == ST_IDLE))
      else $error("build end did not clear the total");

   // a finished map word always lands in the output register
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAP_OUT && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("map response lost");

endmodule

>>> test/tb_histogram_equalizer_unit.sv
// self-checking testbench of the histogram equalizer: count, build and map passes
module tb_histogram_equalizer_unit import heq_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEVELS      = DEF_LEVELS;
   localparam int COUNT_BITS  = DEF_COUNT_BITS;
   localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
   localparam int TOP_LEVEL   = LEVELS - 1;

   // build walks every bin with one quotient bit per cycle
   localparam int BUILD_CYCLES = (5 + $clog2(LEVELS)) * LEVELS;
   localparam int HOLD_CYCLES  = 500;
   localparam int IDLE_LIMIT   = 5 * (BUILD_CYCLES + LEVELS + HOLD_CYCLES);
   localparam int SETTLE_CYCLES = BUILD_CYCLES + 64;
   localparam int RANDOM_FRAME_WORDS = 1150;
   localparam int NOISE_WORDS  = 150;
   localparam int HOLD_WORDS   = 40;

   logic clock;
   logic reset;

   heq_req_if req_chan ();
   heq_rsp_if rsp_chan ();

   histogram_equalizer_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predictor state, kept at the widths of the block
   bit [COUNT_BITS-1:0] gray_hist [LEVELS];
   bit [COUNT_BITS-1:0] pixel_count;
   bit [CHAN_W-1:0]     level_lut [LEVELS];
   bit [COUNT_BITS-1:0] cdf_sum;

   // equalized pixels still to come out of the block, oldest first
   heq_rsp_type pending_pixels [$];

   int unsigned error_count;
   int unsigned words_sent;
   int unsigned count_words;
   int unsigned map_words;
   int unsigned table_builds;
   int unsigned pixels_checked;

   // sender burst shaping
   int unsigned burst_left;

   // long receiver hold-off, requested by a test and counted by the receiver
   bit hold_request;
   int unsigned hold_left;

   int unsigned idle_cycles;

   // ---------------------------------------------------------------- clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------ predictor

   function automatic int unsigned clamp_level(int unsigned v);
      return (v >= LEVELS) ? TOP_LEVEL : v;
   endfunction

   function automatic bit [COUNT_BITS-1:0] sat_add(bit [COUNT_BITS-1:0] a,
                                                   bit [COUNT_BITS-1:0] b);
      longint unsigned s;
      s = longint'(a) + longint'(b);
      if (s > COUNT_MAX)
         s = COUNT_MAX;
      return s[COUNT_BITS-1:0];
   endfunction

   // cumulative sum, half-up rounded table entry, then clear the histogram
   function automatic void build_level_lut();
      longint unsigned total;
      longint unsigned entry;
      total   = 64'(pixel_count);
      cdf_sum = '0;
      for (int i = 0; i < LEVELS; i++) begin
         cdf_sum = sat_add(cdf_sum, gray_hist[i]);
         entry   = '0;
         if (total != 0) begin
            entry = (2 * longint'(cdf_sum) * TOP_LEVEL + total) / (2 * total);
            if (entry > TOP_LEVEL)
               entry = TOP_LEVEL;
         end
         level_lut[i] = entry[CHAN_W-1:0];
      end
      for (int i = 0; i < LEVELS; i++)
         gray_hist[i] = '0;
      pixel_count = '0;
      table_builds++;
   endfunction

   function automatic void count_gray(heq_req_type w);
      int unsigned lvl;
      lvl = clamp_level((int'(w.red_in) + int'(w.green_in) + int'(w.blue_in)) / 3);
      gray_hist[lvl] = sat_add(gray_hist[lvl], COUNT_BITS'(1));
      pixel_count    = sat_add(pixel_count, COUNT_BITS'(1));
      if (w.end_of_frame)
         build_level_lut();
   endfunction

   function automatic heq_rsp_type equalize_pixel(heq_req_type w);
      heq_rsp_type p;
      p.red_out   = level_lut[clamp_level(32'(w.red_in))];
      p.green_out = level_lut[clamp_level(32'(w.green_in))];
      p.blue_out  = level_lut[clamp_level(32'(w.blue_in))];
      return p;
   endfunction

   function automatic void clear_predictor();
      for (int i = 0; i < LEVELS; i++) begin
         gray_hist[i] = '0;
         level_lut[i] = '0;
      end
      pixel_count = '0;
      cdf_sum     = '0;
   endfunction

   // --------------------------------------------------------------- sender

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(heq_req_type w);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         // now and then a long stretch with no gaps at all
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 20);
      end
      burst_left--;
      req_chan.valid <= 1'b1;
      req_chan.data  <= w;
      do
         @(posedge clock);
      while (!req_chan.ready);
      words_sent++;
      if (w.opcode == OP_MAP) begin
         pending_pixels.push_back(equalize_pixel(w));
         map_words++;
      end else begin
         count_gray(w);
         count_words++;
      end
      @(negedge clock);
   endtask

   function automatic heq_req_type make_word(logic op, int unsigned r, int unsigned g,
                                             int unsigned b, logic eof);
      heq_req_type w;
      w.opcode       = op;
      w.red_in       = r[CHAN_W-1:0];
      w.green_in     = g[CHAN_W-1:0];
      w.blue_in      = b[CHAN_W-1:0];
      w.end_of_frame = eof;
      return w;
   endfunction

   function automatic heq_req_type random_map_word();
      return make_word(OP_MAP, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), 1'($urandom_range(0, 1)));
   endfunction

   // ----------------------------------------------------------- receiver

   // stall pattern picked per window; a requested hold-off overrides it
   initial begin : rsp_stall
      int unsigned window_left;
      int unsigned mode;
      int unsigned phase;
      rsp_chan.ready = 1'b0;
      window_left = 0;
      mode  = 0;
      phase = 0;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (window_left == 0) begin
               window_left = $urandom_range(16, 80);
               mode = $urandom_range(0, 3);
            end
            window_left--;
            phase = (phase + 1) % 3;
            case (mode)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= 1'($urandom_range(0, 1));
               2: rsp_chan.ready <= (phase == 0);
               default: rsp_chan.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------- checker

   function automatic void check_channel(string name, bit [CHAN_W-1:0] want,
                                         logic [CHAN_W-1:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      heq_rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_pixels.size() == 0) begin
            $error("response word with no pixel expected: %h", rsp_chan.data);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            check_channel("red_out", want.red_out, rsp_chan.data.red_out);
            check_channel("green_out", want.green_out, rsp_chan.data.green_out);
            check_channel("blue_out", want.blue_out, rsp_chan.data.blue_out);
            pixels_checked++;
         end
      end
   end

   // ------------------------------------------------------------ watchdog

   // counts cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // --------------------------------------------------------------- tests

   // table is all zero until the first build; end mark on a map word is ignored
   task automatic test_map_before_build();
      send_word(make_word(OP_MAP, 0, 0, 0, 1'b0));
      send_word(make_word(OP_MAP, 255, 255, 255, 1'b0));
      send_word(make_word(OP_MAP, 'h55, 'hAA, 'h0F, 1'b1));
   endtask

   // frame of extreme pixels, gray levels at both ends and a rounding split
   task automatic test_extreme_frame();
      send_word(make_word(OP_COUNT, 0, 0, 0, 1'b0));
      send_word(make_word(OP_COUNT, 255, 255, 255, 1'b0));
      send_word(make_word(OP_COUNT, 255, 0, 0, 1'b0));
      send_word(make_word(OP_COUNT, 1, 1, 0, 1'b0));
      send_word(make_word(OP_COUNT, 2, 2, 2, 1'b0));
      send_word(make_word(OP_COUNT, 128, 127, 129, 1'b1));
      send_word(make_word(OP_MAP, 0, 0, 0, 1'b0));
      send_word(make_word(OP_MAP, 255, 255, 255, 1'b0));
      send_word(make_word(OP_MAP, 85, 84, 86, 1'b1));
      send_word(make_word(OP_MAP, 1, 2, 128, 1'b0));
   endtask

   // one pixel frame: table steps from 0 straight to the top level
   task automatic test_single_pixel_frame();
      send_word(make_word(OP_COUNT, 100, 100, 100, 1'b1));
      send_word(make_word(OP_MAP, 99, 100, 255, 1'b0));
      send_word(make_word(OP_MAP, 0, 101, 100, 1'b1));
   endtask

   // well-formed frames: count pass closed by the end mark, then a map pass
   task automatic test_random_frames(int unsigned budget);
      int unsigned start;
      int unsigned n_count;
      int unsigned n_map;
      int unsigned kind;
      int unsigned base;
      int unsigned spread;
      int unsigned r;
      int unsigned g;
      int unsigned b;
      start = words_sent;
      while (words_sent - start < budget) begin
         n_count = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 30);
         n_map   = $urandom_range(5, 40);
         kind    = $urandom_range(0, 2);
         spread  = $urandom_range(1, 64);
         base    = $urandom_range(0, 255 - spread);
         for (int i = 0; i < n_count; i++) begin
            case (kind)
               0: begin
                  r = $urandom_range(0, 255);
                  g = $urandom_range(0, 255);
                  b = $urandom_range(0, 255);
               end
               1: begin
                  // low contrast band
                  r = base + $urandom_range(0, spread);
                  g = base + $urandom_range(0, spread);
                  b = base + $urandom_range(0, spread);
               end
               default: begin
                  r = base + $urandom_range(0, spread);
                  g = r;
                  b = r;
               end
            endcase
            // an occasional map word mid-frame still reads the previous table
            if ($urandom_range(0, 15) == 0)
               send_word(random_map_word());
            send_word(make_word(OP_COUNT, r, g, b, i == n_count - 1));
         end
         for (int i = 0; i < n_map; i++)
            send_word(random_map_word());
      end
   endtask

   // any mix of words, end marks at random on both passes
   task automatic test_noise(int unsigned n);
      logic op;
      for (int i = 0; i < n; i++) begin
         op = 1'($urandom_range(0, 1));
         if (op == OP_MAP)
            send_word(random_map_word());
         else
            send_word(make_word(OP_COUNT, $urandom_range(0, 255), $urandom_range(0, 255),
                                $urandom_range(0, 255), $urandom_range(0, 3) == 0));
      end
   endtask

   // receiver holds off long while map words keep coming, so input stalls
   task automatic test_output_hold(int unsigned n);
      hold_request = 1'b1;
      for (int i = 0; i < n; i++)
         send_word(random_map_word());
   endtask

   // ---------------------------------------------------------------- main
   initial begin
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      hold_request   = 1'b0;
      hold_left      = 0;
      idle_cycles    = 0;
      burst_left     = 0;
      error_count    = 0;
      words_sent     = 0;
      count_words    = 0;
      map_words      = 0;
      table_builds   = 0;
      pixels_checked = 0;
      clear_predictor();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_map_before_build();
      test_extreme_frame();
      test_single_pixel_frame();
      test_random_frames(RANDOM_FRAME_WORDS / 2);
      test_output_hold(HOLD_WORDS);
      test_noise(NOISE_WORDS);
      test_random_frames(RANDOM_FRAME_WORDS / 2);

      // drain: every expected pixel back, then let a trailing build finish
      req_chan.valid <= 1'b0;
      while (pending_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_pixels.size() != 0) begin
         $error("%0d expected pixels never came out", pending_pixels.size());
         error_count++;
      end

      $display("run covered %0d count words and %0d map words, %0d table builds,",
               count_words, map_words, table_builds);
      $display("%0d pixels compared, incl. map before build, extreme frames, long hold-off",
               pixels_checked);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> histogram_equalizer_unit.f
rtl/heq_pkg.sv
rtl/heq_if.sv
rtl/histogram_equalizer_unit.sv
test/tb_histogram_equalizer_unit.sv
